// ===== sv/tcw_pkg.sv =====
// Shared types, codes and constants for the text console writer.
// No dependencies; every other file in sv/ refers to it by scoped names.
`default_nettype none

package tcw_pkg;

    // Default geometry, handed to the top-level parameters
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    // Fixed field widths of the stream payloads
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;
    localparam int OLOC_W  = 11;

    // Cell value after reset: white-on-black space
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0F20;

    // Character codes with a special meaning
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FG = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BG = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL_PRIME,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [CHAR_W-1:0]  char_code;
        logic [CMD_W-1:0]   cmd;
    } command_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [OLOC_W-1:0] cursor_pos;
        logic [OROW_W-1:0] cursor_row;
        logic [OCOL_W-1:0] cursor_col;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Cell buffer of the text console: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
`default_nettype none

module tcw_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [ADDR_W-1:0]           raddr,
    output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Sequencer of the text console: cursor tracking, command execution and the
// address counters that sweep the cell buffer. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP,
    parameter int ADDR_W   = $clog2(COLUMNS * ROWS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tcw_pkg::command_t           in_cmd,
    input  wire logic [7:0]                  attr,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output tcw_pkg::result_t                 res,
    output logic                             mem_we,
    output logic      [ADDR_W-1:0]           mem_waddr,
    output logic      [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic                             mem_re,
    output logic      [ADDR_W-1:0]           mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int SCROLL_LIM = (ROWS - 1) * COLUMNS;
    localparam int CNT_W      = $clog2(CELLS + COLUMNS + 1);
    localparam int COL_W      = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int LOC_W      = $clog2(CELLS + TAB_STOP + 1);
    localparam int PH_W       = $clog2(TAB_STOP);
    localparam int IDXW_W     = CNT_W + tcw_pkg::INDEX_W;
    localparam int OCW        = tcw_pkg::OCOL_W;
    localparam int ORW        = tcw_pkg::OROW_W;
    localparam int OLW        = tcw_pkg::OLOC_W;

    tcw_pkg::state_t   state_reg, state_next;
    tcw_pkg::command_t cmd_reg, cmd_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LOC_W-1:0]  loc_reg, loc_next;
    logic [PH_W-1:0]   ph_reg, ph_next;
    logic              rd_hit_reg, rd_hit_next;
    logic [CNT_W-1:0]  dst_reg, dst_next;
    logic [CNT_W-1:0]  src_reg, src_next;

    logic [tcw_pkg::CELL_W-1:0] blank;
    logic [COL_W-1:0]           tab_col;
    logic [LOC_W-1:0]           tab_loc;
    logic [LOC_W-1:0]           line_loc;
    logic [LOC_W-1:0]           loc_dec;
    logic [PH_W-1:0]            ph_inc;
    logic [PH_W-1:0]            ph_dec;
    logic [IDXW_W-1:0]          idx_wide;
    logic                       idx_in_range;
    logic [COL_W+OCW-1:0]       col_wide;
    logic [ROW_W+ORW-1:0]       row_wide;
    logic [LOC_W+OLW-1:0]       loc_wide;

    assign blank    = {attr, tcw_pkg::CH_SPACE};
    assign tab_col  = col_reg + COL_W'(TAB_STOP) - COL_W'(ph_reg);
    assign tab_loc  = loc_reg + LOC_W'(TAB_STOP) - LOC_W'(ph_reg);
    assign line_loc = loc_reg - LOC_W'(col_reg) + LOC_W'(COLUMNS);
    assign loc_dec  = loc_reg - LOC_W'(1);
    assign ph_inc   = (ph_reg == PH_W'(TAB_STOP - 1)) ? '0 : ph_reg + PH_W'(1);
    assign ph_dec   = (ph_reg == '0) ? PH_W'(TAB_STOP - 1) : ph_reg - PH_W'(1);

    assign idx_wide     = {{CNT_W{1'b0}}, cmd_reg.cell_index};
    assign idx_in_range = idx_wide < IDXW_W'(CELLS);

    // Report the cursor truncated to the result field widths
    assign col_wide = {{OCW{1'b0}}, col_reg};
    assign row_wide = {{ORW{1'b0}}, row_reg};
    assign loc_wide = {{OLW{1'b0}}, loc_reg};

    always_comb
    begin
        res.cursor_col = col_wide[OCW-1:0];
        res.cursor_row = row_wide[ORW-1:0];
        res.cursor_pos = loc_wide[OLW-1:0];
        res.cell_data  = rd_hit_reg ? mem_rdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcw_pkg::S_INIT;
            col_reg    <= '0;
            row_reg    <= '0;
            loc_reg    <= '0;
            ph_reg     <= '0;
            rd_hit_reg <= 1'b0;
            dst_reg    <= '0;
            src_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            loc_reg    <= loc_next;
            ph_reg     <= ph_next;
            rd_hit_reg <= rd_hit_next;
            dst_reg    <= dst_next;
            src_reg    <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        loc_next    = loc_reg;
        ph_next     = ph_reg;
        rd_hit_next = rd_hit_reg;
        dst_next    = dst_reg;
        src_next    = src_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = dst_reg[ADDR_W-1:0];
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = src_reg[ADDR_W-1:0];

        case (state_reg)
            tcw_pkg::S_INIT:
            begin
                mem_wdata = tcw_pkg::BLANK_RESET;
                mem_we    = 1'b1;
                dst_next  = dst_reg + CNT_W'(1);
                if (dst_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end

            tcw_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = in_cmd;
                    state_next = tcw_pkg::S_EXEC;
                end
            end

            tcw_pkg::S_EXEC:
            begin
                rd_hit_next = 1'b0;
                state_next  = tcw_pkg::S_DONE;
                case (cmd_reg.cmd)
                    tcw_pkg::CMD_WRITE:
                    begin
                        case (cmd_reg.char_code)
                            tcw_pkg::CH_BS:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next  = col_reg - COL_W'(1);
                                    loc_next  = loc_dec;
                                    ph_next   = ph_dec;
                                    mem_we    = 1'b1;
                                    mem_waddr = loc_dec[ADDR_W-1:0];
                                end
                            end
                            tcw_pkg::CH_TAB:
                            begin
                                ph_next = '0;
                                if (tab_col >= COL_W'(COLUMNS))
                                begin
                                    col_next = '0;
                                    row_next = row_reg + ROW_W'(1);
                                    loc_next = line_loc;
                                end
                                else
                                begin
                                    col_next = tab_col;
                                    loc_next = tab_loc;
                                end
                            end
                            tcw_pkg::CH_CR:
                            begin
                                col_next = '0;
                                ph_next  = '0;
                                loc_next = loc_reg - LOC_W'(col_reg);
                            end
                            tcw_pkg::CH_LF:
                            begin
                                col_next = '0;
                                ph_next  = '0;
                                row_next = row_reg + ROW_W'(1);
                                loc_next = line_loc;
                            end
                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = loc_reg[ADDR_W-1:0];
                                mem_wdata = {attr, cmd_reg.char_code};
                                loc_next  = loc_reg + LOC_W'(1);
                                if (col_reg == COL_W'(COLUMNS - 1))
                                begin
                                    col_next = '0;
                                    ph_next  = '0;
                                    row_next = row_reg + ROW_W'(1);
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                    ph_next  = ph_inc;
                                end
                            end
                        endcase
                        // Cursor ran off the bottom: scroll, cursor to last row
                        if (row_next == ROW_W'(ROWS))
                        begin
                            row_next   = ROW_W'(ROWS - 1);
                            loc_next   = LOC_W'(SCROLL_LIM);
                            dst_next   = '0;
                            src_next   = CNT_W'(COLUMNS);
                            state_next = tcw_pkg::S_SCROLL_PRIME;
                        end
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        loc_next   = '0;
                        ph_next    = '0;
                        dst_next   = '0;
                        state_next = tcw_pkg::S_CLEAR;
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        if (idx_in_range)
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = idx_wide[ADDR_W-1:0];
                            rd_hit_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = tcw_pkg::S_DONE;
                    end
                endcase
            end

            tcw_pkg::S_SCROLL_PRIME:
            begin
                // Fetch the first cell of row 1 ahead of the copy
                mem_re     = 1'b1;
                src_next   = src_reg + CNT_W'(1);
                state_next = tcw_pkg::S_SCROLL;
            end

            tcw_pkg::S_SCROLL:
            begin
                mem_we = 1'b1;
                if (dst_reg < CNT_W'(SCROLL_LIM))
                begin
                    mem_wdata = mem_rdata;
                end
                if (src_reg < CNT_W'(CELLS))
                begin
                    mem_re = 1'b1;
                end
                src_next = src_reg + CNT_W'(1);
                dst_next = dst_reg + CNT_W'(1);
                if (dst_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_DONE;
                end
            end

            tcw_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                dst_next = dst_reg + CNT_W'(1);
                if (dst_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_DONE;
                end
            end

            tcw_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd_next   = in_cmd;
                        state_next = tcw_pkg::S_EXEC;
                    end
                    else
                    begin
                        state_next = tcw_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer_top.sv =====
// Top level of the text console writer: stream ports, color registers,
// result register. Depends on tcw_pkg, tcw_ram and tcw_ctrl.
`default_nettype none

// Text-mode console with a COLUMNS x ROWS cell buffer (80 x 25 by default)
// and a cursor. Each command on the slave stream produces exactly one
// result on the master stream carrying the cursor after the command, and
// for a read command the addressed cell (attribute byte high, character
// byte low; zero for an out-of-range index or any other command). After
// reset the block fills the buffer with white-on-black blanks before
// tready rises. A printable character, control code or read is executed
// against the buffer in S_EXEC and its result offered in S_DONE, where the
// next command can be taken as soon as the result is. A clear sweeps the
// buffer one cell per cycle; a write that pushes the cursor past the bottom
// row scrolls the buffer through its single read and single write port,
// one cell per cycle. A finished result waits in the output register, so
// the next command can be taken while the master side stalls. Color
// registers (index 0 foreground, index 1 background) may be written at any
// time the block is idle; they set the attribute of every later character
// and blank.

module text_console_writer_top #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,  // cmd, char_code, cell_index
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [39:0]                     m_tdata,  // cursor_col, cursor_row,
                                                           // cursor_pos, cell_data
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [tcw_pkg::COLOR_W-1:0]     cfg_wdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [tcw_pkg::COLOR_W-1:0] fg_reg, fg_next;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg, bg_next;
    logic                        out_valid_reg, out_valid_next;
    tcw_pkg::result_t            out_reg;

    tcw_pkg::command_t           in_cmd;
    tcw_pkg::result_t            res;
    logic                        res_valid;
    logic                        res_take;

    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

    // Unpack the command transaction, lowest field first
    always_comb
    begin
        in_cmd.cmd        = s_tdata[1:0];
        in_cmd.char_code  = s_tdata[9:2];
        in_cmd.cell_index = s_tdata[20:10];
    end

    // Color registers; an index beyond the list changes nothing
    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                tcw_pkg::REG_FG: fg_next = cfg_wdata;
                tcw_pkg::REG_BG: bg_next = cfg_wdata;
                default:
                begin
                    fg_next = fg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'hF;
            bg_reg <= 4'h0;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    // Output register: load a finished result when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    tcw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .attr      ({bg_reg, fg_reg}),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== tb/console_check_pkg.sv =====
// Screen tracker for the text console writer testbench: predicts every cursor report.
// Depends on tcw_pkg for field widths, command codes, character codes and register indexes.
package console_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int SCREEN_COLS = DEF_COLUMNS;
    localparam int SCREEN_ROWS = DEF_ROWS;
    localparam int TAB_WIDTH   = DEF_TAB_STOP;
    localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_SHOWN   = 10;

    // command code with no function; the block must only report the cursor
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class screen_tracker;
        logic [CELL_W-1:0]  cells [CELLS];
        int                 cur_col;
        int                 cur_row;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        result_t            expected_reports [$];
        int                 errors;

        function new();
            fg     = 4'hF;
            bg     = 4'h0;
            errors = 0;
            blank_screen();
        endfunction

        function logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch);
            return {bg, fg, ch};
        endfunction

        function void blank_screen();
            foreach (cells[i])
                cells[i] = make_cell(CH_SPACE);
            cur_col = 0;
            cur_row = 0;
        endfunction

        function void advance_row();
            cur_col = 0;
            cur_row++;
        endfunction

        function void type_char(logic [CHAR_W-1:0] ch);
            case (ch)
                CH_BS:
                    if (cur_col != 0)
                    begin
                        cur_col--;
                        cells[cur_row * SCREEN_COLS + cur_col] = make_cell(CH_SPACE);
                    end
                CH_TAB:
                begin
                    cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
                    if (cur_col >= SCREEN_COLS)
                        advance_row();
                end
                CH_CR:
                    cur_col = 0;
                CH_LF:
                    advance_row();
                default:
                begin
                    cells[cur_row * SCREEN_COLS + cur_col] = make_cell(ch);
                    cur_col++;
                    if (cur_col >= SCREEN_COLS)
                        advance_row();
                end
            endcase
            // past the bottom row: shift everything up one row, blank the last row
            if (cur_row >= SCREEN_ROWS)
            begin
                for (int i = 0; i < CELLS - SCREEN_COLS; i++)
                    cells[i] = cells[i + SCREEN_COLS];
                for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
                    cells[i] = make_cell(CH_SPACE);
                cur_row = SCREEN_ROWS - 1;
            end
        endfunction

        function void set_color(logic [CFG_ADDR_W-1:0] addr, logic [COLOR_W-1:0] value);
            if (addr == REG_FG)
                fg = value;
            else if (addr == REG_BG)
                bg = value;
        endfunction

        function void note_command(command_t c);
            result_t report;
            report.cell_data = '0;
            case (c.cmd)
                CMD_WRITE:
                    type_char(c.char_code);
                CMD_CLEAR:
                    blank_screen();
                CMD_READ:
                    if (c.cell_index < CELLS)
                        report.cell_data = cells[c.cell_index];
                default:
                    ;
            endcase
            report.cursor_col = OCOL_W'(cur_col);
            report.cursor_row = OROW_W'(cur_row);
            report.cursor_pos = OLOC_W'(cur_row * SCREEN_COLS + cur_col);
            expected_reports.push_back(report);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%s", msg);
        endfunction

        function void compare_field(string name, logic [CELL_W-1:0] want,
                                    logic [CELL_W-1:0] got);
            if (got !== want)
                flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (expected_reports.size() == 0)
            begin
                flag($sformatf("unexpected cursor report: col %0d row %0d pos %0d data 0x%0h",
                               got.cursor_col, got.cursor_row, got.cursor_pos, got.cell_data));
                return;
            end
            want = expected_reports.pop_front();
            compare_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(got.cursor_col));
            compare_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
            compare_field("cursor_pos", CELL_W'(want.cursor_pos), CELL_W'(got.cursor_pos));
            compare_field("cell_data", want.cell_data, got.cell_data);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function bit failed();
            return errors != 0 || expected_reports.size() != 0;
        endfunction

        function int cursor_pos();
            return cur_row * SCREEN_COLS + cur_col;
        endfunction
    endclass

endpackage

// ===== tb/text_console_writer_top_test.sv =====
// Testbench top for text_console_writer_top: drives commands and color writes, checks reports.
// Depends on tcw_pkg, console_check_pkg and the RTL under sv/.
module text_console_writer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;
    import console_check_pkg::*;

    localparam int ITEMS_TOTAL    = 1650;
    localparam int PHASES         = 6;
    localparam int RX_HOLD_AFTER  = 600;    // reports seen before the long receiver hold-off
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT     = 20000;  // well above the longest init fill or scroll
    localparam int DRAIN_CYCLES   = 50;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // cmd, char_code, cell_index
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;          // cursor_col, cursor_row, cursor_pos, cell_data
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [COLOR_W-1:0]    cfg_wdata = '0;

    screen_tracker tracker = new();

    int items_sent   = 0;
    int reports_seen = 0;
    int tx_burst     = 0;
    int rx_burst     = 0;

    text_console_writer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long,
    // and occasionally a run of back-to-back transactions with no idling at all.
    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Offer one command and hold it until the block takes it. Entered and left
    // on a rising edge; on return the transaction has just been accepted.
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx);
        command_t c;
        int       gap;
        c.cmd        = cmd;
        c.char_code  = ch;
        c.cell_index = idx;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 24'(c);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_command(c);
        items_sent++;
    endtask

    // unused fields carry random junk, the block must ignore them
    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_cmd(CMD_WRITE, ch, INDEX_W'($urandom));
    endtask

    task automatic read_cell(logic [INDEX_W-1:0] idx);
        send_cmd(CMD_READ, CHAR_W'($urandom), idx);
    endtask

    // read up to 90 cells before the cursor, where recent writes landed
    task automatic read_near_cursor();
        int loc;
        loc = tracker.cursor_pos() - int'($urandom_range(0, 90));
        if (loc < 0)
            loc = 0;
        read_cell(INDEX_W'(loc));
    endtask

    // Drop valid and wait until every report has come back: the block is idle.
    // Always entered right after an acceptance, so at least one edge passes.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FG;
        cfg_wdata <= fg;
        @(posedge clk);
        tracker.set_color(REG_FG, fg);
        cfg_addr  <= REG_BG;
        cfg_wdata <= bg;
        @(posedge clk);
        tracker.set_color(REG_BG, bg);
        cfg_we    <= 1'b0;
    endtask

    // Short, hand-picked sequence from a freshly filled screen.
    task automatic run_directed();
        read_cell('0);                      // first cell, reset blank
        read_cell(INDEX_W'(CELLS - 1));     // last cell
        read_cell(INDEX_W'(CELLS));         // first index past the screen reads zero
        read_cell('1);                      // largest index
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);                    // zero byte is printable too
        put_char(CH_BS);                    // blanks the cell just written
        read_cell(INDEX_W'(2));
        put_char(CH_TAB);                   // mid-stop to the next tab stop
        put_char(CH_CR);
        put_char(CH_BS);                    // at column 0: no effect
        put_char(CH_LF);
        send_cmd(CMD_UNUSED, '1, '1);
        // walk tab stops across the row; the last one wraps to the next line
        repeat (SCREEN_COLS / TAB_WIDTH) put_char(CH_TAB);
        send_cmd(CMD_CLEAR, '1, '1);
    endtask

    // A text line: mostly printable characters with the odd backspace, tab
    // and read-back, ended by CR LF, a bare LF or nothing. Lines are mostly
    // short so the cursor reaches the bottom row and scrolls regularly.
    task automatic send_line();
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            len = $urandom_range(0, 6);
        else if (r < 90)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(70, 100);
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                put_char(CH_BS);
            else if (r < 10)
                put_char(CH_TAB);
            else if (r < 18)
                read_near_cursor();
            else if (r < 90)
                put_char(CHAR_W'($urandom_range(32, 126)));
            else
                put_char(CHAR_W'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 30)
            put_char(CH_CR);
        if (r < 80)
            put_char(CH_LF);
    endtask

    task automatic run_traffic(int stop, bit pause_midway);
        int midpoint;
        int r;
        midpoint = (items_sent + stop) / 2;
        while (items_sent < stop)
        begin
            // sender steps back until the block has answered everything
            if (pause_midway && items_sent >= midpoint)
            begin
                pause_midway = 1'b0;
                finish_phase();
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                send_line();
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        read_near_cursor();
                    else if (r < 85)
                        read_cell(INDEX_W'($urandom_range(0, CELLS - 1)));
                    else
                        read_cell(INDEX_W'($urandom_range(CELLS, 2 ** INDEX_W - 1)));
                end
            end
            else if (r < 92)
            begin
                // noise: any command with any field values
                repeat ($urandom_range(1, 4))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        put_char(CHAR_W'($urandom));
                    else if (r < 60)
                        read_cell(INDEX_W'($urandom));
                    else if (r < 70)
                        send_cmd(CMD_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
                    else
                        send_cmd(CMD_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
                end
            end
            else
                repeat ($urandom_range(1, 12)) put_char(CH_TAB);
        end
    endtask

    // Every accepted report goes to the tracker; sampled at the edge, so the
    // values are the ones the block held going into it.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            tracker.check_report(result_t'(m_tdata[$bits(result_t)-1:0]));
            reports_seen++;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off while the sender
    // keeps offering, so the result register and then the input side stall.
    initial
    begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && reports_seen >= RX_HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap(rx_burst);
                if (gap == 0)
                begin
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either stream for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed commands, then phases of random traffic.
    // Colors change only between phases, once every report has come back;
    // the first phase keeps the reset colors, the next three cover the extremes, the rest are random.
    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                finish_phase();
                case (p)
                    1: write_colors(4'h0, 4'hF);
                    2: write_colors(4'h0, 4'h0);
                    3: write_colors(4'hF, 4'hF);
                    default: write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
                endcase
            end
            run_traffic(items_sent + (ITEMS_TOTAL - items_sent) / (PHASES - p), p == 2);
        end
        finish_phase();
        // let any stray report show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failed())
            $display("CHECK FAILED");
        else
            $display("CHECK OK");
        $finish;
    end

endmodule
